// ===== src/ilpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ilpd_pkg
// Shared types, constants and helpers of the intercom line pulse decoder.
// ----------------------------------------------------------------------------
package ilpd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LIMIT_W    = 16;
    localparam int FLAT_W     = 15;
    localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [FLAT_W-1:0]     FLAT_MAX  = {FLAT_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [LIMIT_W-1:0] DISCONNECT_RST = LIMIT_W'(1000);
    localparam logic [LIMIT_W-1:0] CALL_START_RST = LIMIT_W'(50);
    localparam logic [LIMIT_W-1:0] DATA_END_RST   = LIMIT_W'(100);
    localparam logic [LIMIT_W-1:0] RECONNECT_RST  = LIMIT_W'(100);
    localparam logic [LIMIT_W-1:0] CALL_END_RST   = LIMIT_W'(500);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_RECEIVING = 3'd2,
        ST_DATA      = 3'd3,
        ST_ENDED     = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        LINK_DOWN = 2'd0,
        LINK_UP   = 2'd1,
        LINK_RX   = 2'd2
    } link_t;

    typedef enum logic [2:0] {
        REG_DISCONNECT = 3'd0,
        REG_CALL_START = 3'd1,
        REG_DATA_END   = 3'd2,
        REG_RECONNECT  = 3'd3,
        REG_CALL_END   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] disconnect_low;
        logic [LIMIT_W-1:0] call_start_low;
        logic [LIMIT_W-1:0] data_end_low;
        logic [LIMIT_W-1:0] reconnect_high;
        logic [LIMIT_W-1:0] call_end_low;
    } cfg_t;

    typedef struct packed {
        state_t            line_state;
        link_t             link_status;
        logic              led_on;
        logic              flat_valid;
        logic [FLAT_W-1:0] flat_number;
    } result_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic reached(input logic [COUNT_BITS-1:0] cnt,
                                     input logic [LIMIT_W-1:0]    lim);
        return CMP_W'(cnt) >= CMP_W'(lim);
    endfunction

endpackage

// ===== src/ilpd_fsm.sv =====
// ----------------------------------------------------------------------------
// ilpd_fsm
// Line state machine with saturating low, high and falling-edge counters.
// ----------------------------------------------------------------------------
module ilpd_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             level,
    input  ilpd_pkg::cfg_t   cfg,
    output ilpd_pkg::result_t res
);
    import ilpd_pkg::*;

    state_t                state_reg,  state_next;
    link_t                 status_reg, status_next;
    logic                  lamp_reg,   lamp_next;
    logic                  last_reg,   last_next;
    logic [COUNT_BITS-1:0] low_reg,    low_next;
    logic [COUNT_BITS-1:0] high_reg,   high_next;
    logic [COUNT_BITS-1:0] edge_reg,   edge_next;

    logic                  enter_en;
    state_t                enter_st;
    logic                  flat_valid;
    logic [FLAT_W-1:0]     flat_number;
    logic [CMP_W-1:0]      half;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        lamp_next   = lamp_reg;
        last_next   = last_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        edge_next   = edge_reg;
        enter_en    = 1'b0;
        enter_st    = state_reg;
        flat_valid  = 1'b0;
        flat_number = '0;
        half        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (level)
                begin
                    enter_en = 1'b1;
                    enter_st = ST_CONNECTED;
                end
            end
            ST_CONNECTED:
            begin
                if (!level)
                begin
                    low_next = sat_inc(low_reg);
                    if (reached(low_next, cfg.disconnect_low))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_IDLE;
                    end
                end
                else if (reached(low_reg, cfg.call_start_low))
                begin
                    enter_en = 1'b1;
                    enter_st = ST_RECEIVING;
                end
            end
            ST_RECEIVING:
            begin
                if (last_reg && !level)
                    edge_next = sat_inc(edge_reg);
                last_next = level;
                if (!level)
                begin
                    high_next = '0;
                    low_next  = sat_inc(low_reg);
                    if (reached(low_next, cfg.data_end_low))
                    begin
                        half = CMP_W'(edge_next >> 1);
                        if (half != '0)
                        begin
                            flat_valid  = 1'b1;
                            flat_number = (half > CMP_W'(FLAT_MAX)) ? FLAT_MAX
                                                                    : half[FLAT_W-1:0];
                        end
                        enter_en = 1'b1;
                        enter_st = ST_DATA;
                    end
                end
                else
                begin
                    low_next  = '0;
                    high_next = sat_inc(high_reg);
                    if (reached(high_next, cfg.reconnect_high))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_CONNECTED;
                    end
                end
            end
            ST_DATA:
            begin
                if (!level)
                begin
                    low_next = sat_inc(low_reg);
                    if (reached(low_next, cfg.call_end_low))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_ENDED;
                    end
                end
                else
                begin
                    high_next = sat_inc(high_reg);
                    if (reached(high_next, cfg.reconnect_high))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_CONNECTED;
                    end
                end
            end
            default:
            begin
                // call ended, and any unused code
                if (!level)
                begin
                    low_next = sat_inc(low_reg);
                    if (reached(low_next, cfg.disconnect_low))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_IDLE;
                    end
                end
                else
                begin
                    high_next = sat_inc(high_reg);
                    if (reached(high_next, cfg.reconnect_high))
                    begin
                        enter_en = 1'b1;
                        enter_st = ST_CONNECTED;
                    end
                end
            end
        endcase

        if (enter_en)
        begin
            state_next = enter_st;
            low_next   = '0;
            high_next  = '0;
            edge_next  = '0;
            last_next  = 1'b0;
            if (enter_st == ST_IDLE)
            begin
                lamp_next   = 1'b0;
                status_next = LINK_DOWN;
            end
            else if (enter_st == ST_CONNECTED)
            begin
                lamp_next   = 1'b1;
                status_next = LINK_UP;
            end
            else if (enter_st == ST_RECEIVING)
            begin
                status_next = LINK_RX;
            end
        end

        res.line_state  = state_next;
        res.link_status = status_next;
        res.led_on      = lamp_next;
        res.flat_valid  = flat_valid;
        res.flat_number = flat_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CONNECTED;
            status_reg <= LINK_UP;
            lamp_reg   <= 1'b1;
            last_reg   <= 1'b0;
            low_reg    <= '0;
            high_reg   <= '0;
            edge_reg   <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            lamp_reg   <= lamp_next;
            last_reg   <= last_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            edge_reg   <= edge_next;
        end
    end

endmodule

// ===== src/ilpd_out_buf.sv =====
// ----------------------------------------------------------------------------
// ilpd_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module ilpd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ilpd_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output ilpd_pkg::result_t out_data
);
    import ilpd_pkg::*;

    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!main_valid_reg || pop)
            begin
                main_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (!main_valid_reg || pop)
        begin
            if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== src/intercom_line_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// intercom_line_pulse_decoder
// Decodes the flat number from pulse trains on a sampled intercom line.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+---------------------
//  input    | in_valid, in_ready, line_level            | valid & ready
//  output   | out_valid, out_ready, line_state,         | valid & ready
//           | link_status, led_on, flat_valid,          |
//           | flat_number                               |
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB, pready high
//           | prdata, pready                            |
//
//  One sample per cycle while in_ready is high: the state update is a single
//  pass of compares and increments. The result is registered into the output
//  register, or the skid register if that is held, so input flows on past
//  one held result; in_ready drops only while both entries are full. Reset
//  (asynchronous, active low) puts the machine in connected with the lamp
//  on, clears the counters and loads the default limits.
// ----------------------------------------------------------------------------
module intercom_line_pulse_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ilpd_pkg::DATA_W-1:0]   pwdata,
    output logic [ilpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          line_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    line_state,
    output logic [1:0]                    link_status,
    output logic                          led_on,
    output logic                          flat_valid,
    output logic [ilpd_pkg::FLAT_W-1:0]   flat_number
);
    import ilpd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     step;
    result_t  step_res;
    result_t  out_res;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disconnect_low <= DISCONNECT_RST;
            cfg_reg.call_start_low <= CALL_START_RST;
            cfg_reg.data_end_low   <= DATA_END_RST;
            cfg_reg.reconnect_high <= RECONNECT_RST;
            cfg_reg.call_end_low   <= CALL_END_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DISCONNECT: cfg_reg.disconnect_low <= pwdata[LIMIT_W-1:0];
                REG_CALL_START: cfg_reg.call_start_low <= pwdata[LIMIT_W-1:0];
                REG_DATA_END:   cfg_reg.data_end_low   <= pwdata[LIMIT_W-1:0];
                REG_RECONNECT:  cfg_reg.reconnect_high <= pwdata[LIMIT_W-1:0];
                REG_CALL_END:   cfg_reg.call_end_low   <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DISCONNECT: prdata = DATA_W'(cfg_reg.disconnect_low);
            REG_CALL_START: prdata = DATA_W'(cfg_reg.call_start_low);
            REG_DATA_END:   prdata = DATA_W'(cfg_reg.data_end_low);
            REG_RECONNECT:  prdata = DATA_W'(cfg_reg.reconnect_high);
            REG_CALL_END:   prdata = DATA_W'(cfg_reg.call_end_low);
            default:        prdata = '0;
        endcase
    end

    assign step = in_valid && in_ready;

    ilpd_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .level (line_level),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    ilpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign line_state  = out_res.line_state;
    assign link_status = out_res.link_status;
    assign led_on      = out_res.led_on;
    assign flat_valid  = out_res.flat_valid;
    assign flat_number = out_res.flat_number;

endmodule

// ===== src/ilpd_checker.sv =====
// ----------------------------------------------------------------------------
// ilpd_checker
// Port-level checks of the intercom line pulse decoder, bound to the top.
// ----------------------------------------------------------------------------
module ilpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [2:0]                  line_state,
    input logic [1:0]                  link_status,
    input logic                        led_on,
    input logic                        flat_valid,
    input logic [ilpd_pkg::FLAT_W-1:0] flat_number
);
    import ilpd_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({line_state, link_status, led_on, flat_valid, flat_number}))
        else $error("result changed while stalled");

    a_flat_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flat_valid |-> line_state == ST_DATA && flat_number != '0)
        else $error("flat number reported outside data received");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !flat_valid |-> flat_number == '0)
        else $error("flat number not zero without report");

    // lamp off exactly when the link is reported down
    a_lamp_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (link_status == LINK_DOWN) == !led_on)
        else $error("lamp and link status disagree");

    // input only backs up while a result is on offer
    a_full_shown: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind intercom_line_pulse_decoder ilpd_checker u_ilpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_state  (line_state),
    .link_status (link_status),
    .led_on      (led_on),
    .flat_valid  (flat_valid),
    .flat_number (flat_number)
);
